// ===== rtl/core/yuyv_to_rgb_converter_core_macros.svh =====
// Assertion macros for the YUYV to RGB converter core.
// Included by modules that check their own pipeline control.
`ifndef YUYV_TO_RGB_CONVERTER_CORE_MACROS_SVH
`define YUYV_TO_RGB_CONVERTER_CORE_MACROS_SVH

// Implication checked outside reset.
`define YTR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pipeline check failed");

// Next-cycle implication that is also checked across reset.
`define YTR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("pipeline check failed");

`endif

// ===== rtl/core/ytr_pkg.sv =====
// Package for the YUYV to RGB converter core: fixed-point coefficients,
// widths and the clamp and saturate helpers. No dependencies.
package ytr_pkg;

    localparam int unsigned SumW = 26;
    localparam int unsigned ChanW = 8;
    localparam int unsigned ScaleW = 9;
    localparam int unsigned ScaledW = ChanW + ScaleW;

    localparam logic signed [17:0] COEF_RV = 18'sd89831;
    localparam logic signed [17:0] COEF_GV = 18'sd45744;
    localparam logic signed [17:0] COEF_GU = 18'sd22127;
    localparam logic signed [17:0] COEF_BU = 18'sd113538;

    localparam logic [ScaleW-1:0] SCALE_RESET = 9'd220;
    localparam logic [ChanW-1:0] CHAN_MAX = 8'hFF;

    typedef logic signed [SumW-1:0] t_sum;
    typedef logic [ChanW-1:0] t_chan;
    typedef logic [ScaledW-1:0] t_scaled;

    // Floor of a Q.16 sum, clamped to the channel range.
    function automatic t_chan clamp_q16(input t_sum sum);
        t_chan res;
        if (sum[SumW-1]) begin
            res = '0;
        end else if (sum[SumW-2]) begin
            res = CHAN_MAX;
        end else begin
            res = sum[23:16];
        end
        return res;
    endfunction

    // Divide a scaled channel by 256 and saturate to the channel range.
    function automatic t_chan sat_scaled(input t_scaled p);
        t_chan res;
        if (p[ScaledW-1]) begin
            res = CHAN_MAX;
        end else begin
            res = p[ScaledW-2:ChanW];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/yuyv_to_rgb_converter_core.sv =====
// YUYV macropixel to scaled 24-bit colour converter, four register stages:
// chroma products, Q.16 sums with clamp, gain multiply, saturate to output.
// Words pass through the stages in order; one word per cycle while the output is not stalled.
// A stall on the output only holds as many stages as are full.
// Reset is synchronous and active low: pipeline empties, scale returns to 220.
`include "yuyv_to_rgb_converter_core_macros.svh"

module yuyv_to_rgb_converter_core
    import ytr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [ScaleW-1:0]   i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // luma_first, chroma_blue, luma_second, chroma_red
    input  logic [31:0]         s_axis_tdata,
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // first_blue, first_green, first_red, second_blue, second_green, second_red
    output logic [47:0]         m_axis_tdata,
    output logic                m_axis_tlast
);

    localparam int unsigned NumStages = 4;

    logic [ScaleW-1:0]    r_scale;
    logic [NumStages-1:0] r_vld;
    logic [NumStages-1:0] adv;
    logic                 r1_last, r2_last, r3_last, r4_last;

    logic [7:0]  r1_y0, r1_y1;
    t_sum        r1_bu, r1_gv, r1_gu, r1_rv;
    t_chan       r2_chan [6];
    t_scaled     r3_prod [6];
    logic [47:0] r4_data;

    logic signed [8:0]  du, dv;
    logic signed [26:0] p_bu, p_gv, p_gu, p_rv;
    t_sum               base0, base1;
    t_sum               n_sum [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_wr_en) begin
            r_scale <= i_cfg_wr_data;
        end
    end

    always_comb begin
        adv[NumStages-1] = !r_vld[NumStages-1] || m_axis_tready;
        for (int i = NumStages - 2; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NumStages; i++) begin
                if (adv[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Offset chroma: flipping the top bit subtracts 128 in two's complement.
    assign du = {{2{~s_axis_tdata[15]}}, s_axis_tdata[14:8]};
    assign dv = {{2{~s_axis_tdata[31]}}, s_axis_tdata[30:24]};
    assign p_bu = du * COEF_BU;
    assign p_gv = dv * COEF_GV;
    assign p_gu = du * COEF_GU;
    assign p_rv = dv * COEF_RV;

    always_ff @(posedge i_clk) begin
        if (adv[0] && s_axis_tvalid) begin
            r1_y0   <= s_axis_tdata[7:0];
            r1_y1   <= s_axis_tdata[23:16];
            r1_bu   <= p_bu[SumW-1:0];
            r1_gv   <= p_gv[SumW-1:0];
            r1_gu   <= p_gu[SumW-1:0];
            r1_rv   <= p_rv[SumW-1:0];
            r1_last <= s_axis_tlast;
        end
    end

    assign base0 = $signed({2'b00, r1_y0, 16'h0000});
    assign base1 = $signed({2'b00, r1_y1, 16'h0000});

    always_comb begin
        n_sum[0] = base0 + r1_bu;
        n_sum[1] = base0 - r1_gv - r1_gu;
        n_sum[2] = base0 + r1_rv;
        n_sum[3] = base1 + r1_bu;
        n_sum[4] = base1 - r1_gv - r1_gu;
        n_sum[5] = base1 + r1_rv;
    end

    always_ff @(posedge i_clk) begin
        if (adv[1] && r_vld[0]) begin
            for (int i = 0; i < 6; i++) begin
                r2_chan[i] <= clamp_q16(n_sum[i]);
            end
            r2_last <= r1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[2] && r_vld[1]) begin
            for (int i = 0; i < 6; i++) begin
                r3_prod[i] <= r2_chan[i] * r_scale;
            end
            r3_last <= r2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[3] && r_vld[2]) begin
            for (int i = 0; i < 6; i++) begin
                r4_data[i*8 +: 8] <= sat_scaled(r3_prod[i]);
            end
            r4_last <= r3_last;
        end
    end

    assign m_axis_tvalid = r_vld[NumStages-1];
    assign m_axis_tdata  = r4_data;
    assign m_axis_tlast  = r4_last;

    `YTR_ASSERT_IMP(a_accept_fills_first, s_axis_tvalid && s_axis_tready, ##1 r_vld[0])
    `YTR_ASSERT_IMP(a_no_loss, !(m_axis_tvalid && m_axis_tready) && !s_axis_tvalid,
        ##1 $countones(r_vld) >= $past($countones(r_vld)))
    `YTR_ASSERT_IMP(a_ready_when_hole, !r_vld[0], s_axis_tready)
    `YTR_ASSERT_NXT(a_reset_state, !i_rst_n, r_scale == SCALE_RESET && r_vld == '0)

endmodule
